/* hdl/gbt_pkg.sv */
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared types and constants of the g-force ball tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package gbt_pkg;

  // field and state widths
  localparam int unsigned PosW   = 14;  // ball and target, signed
  localparam int unsigned MagW   = 23;  // pixel magnitude before clipping
  localparam int unsigned ProdW  = 46;  // shared multiplier product
  localparam int unsigned AccW   = 47;  // sum of two squares
  localparam int unsigned NumW   = 33;  // divider dividend
  localparam int unsigned DenW   = 24;  // divider divisor
  localparam int unsigned RadW   = 48;  // square root radicand
  localparam int unsigned RootW  = 24;  // square root result
  localparam int unsigned CfgW   = 13;  // widest register

  // item actions
  typedef enum logic [2:0] {
    ACT_SET_TARGET = 3'd0,
    ACT_TICK       = 3'd1,
    ACT_SWEEP_GO   = 3'd2,
    ACT_SWEEP_POS  = 3'd3,
    ACT_SWEEP_END  = 3'd4
  } gbt_action_e;

  // register indexes
  typedef enum logic [2:0] {
    REG_TRACK_SHIFT  = 3'd0,
    REG_MAX_STEP     = 3'd1,
    REG_TARGET_LIMIT = 3'd2,
    REG_FULL_SCALE   = 3'd3,
    REG_DIAL_RADIUS  = 3'd4,
    REG_CLIP_RADIUS  = 3'd5
  } gbt_reg_e;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_BALL_X, MUL_BALL_Y, MUL_PX_SQ, MUL_PY_SQ, MUL_RM_SQ,
    MUL_CLIP_X, MUL_CLIP_Y, MUL_TX_SQ, MUL_TY_SQ
  } gbt_mul_e;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} gbt_acc_e;
  typedef enum logic {DSRC_PIXEL, DSRC_CLIP} gbt_dsrc_e;
  typedef enum logic [1:0] {QDST_NONE, QDST_PX, QDST_PY} gbt_qdst_e;

  // controller to datapath
  typedef struct packed {
    logic      update;
    logic      mul_en;
    gbt_mul_e  mul_sel;
    gbt_acc_e  acc_op;
    logic      rmsq_load;
    logic      div_start;
    gbt_dsrc_e div_src;
    gbt_qdst_e q_dst;
    logic      sqrt_start;
    logic      cmag_load;
    logic      mag_load;
    logic      out_load;
  } gbt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic clip;
  } gbt_stat_t;

endpackage

`default_nettype wire

/* hdl/gbt_div.sv */
// ----------------------------------------------------------------------------
// gbt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_div import gbt_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [NumW-1:0]      quo
);

  localparam int unsigned CntW = $clog2(NumW);
  localparam logic [CntW-1:0] LastStep = CntW'(NumW - 1);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [DenW-1:0] rem;
  logic [DenW-1:0] dvs;
  logic [DenW:0]   trial;
  logic            fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, quo[NumW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= DenW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DenW-1:0];
      end
      quo <= {quo[NumW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* hdl/gbt_sqrt.sv */
// ----------------------------------------------------------------------------
// gbt_sqrt
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_sqrt import gbt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [RadW-1:0]  rad_in,
  output logic                  done,
  output logic [RootW-1:0]      root
);

  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned CntW = $clog2(RootW);
  localparam logic [CntW-1:0] LastStep = CntW'(RootW - 1);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [RadW-1:0] rad;
  logic [RemW-1:0] rem;
  logic [RemW+1:0] tmp;
  logic [RemW+1:0] trial;
  logic            fits;

  // bring down two radicand bits and try root*4+1
  assign tmp   = {rem, rad[RadW-1 -: 2]};
  assign trial = (RemW+2)'({root, 2'b01});
  assign fits  = tmp >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RadW-3:0], 2'b00};
      if (fits) begin
        rem <= RemW'(tmp - trial);
      end else begin
        rem <= tmp[RemW-1:0];
      end
      root <= {root[RootW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* hdl/gbt_datapath.sv */
// ----------------------------------------------------------------------------
// gbt_datapath
// Ball state, registers, shared multiplier, divider and square root.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_datapath import gbt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [2:0]         action,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic [12:0]        sweep_offset,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data,
  input  wire gbt_cmd_t           cmd,
  output gbt_stat_t               stat,
  output logic signed [10:0]      pos_x,
  output logic signed [10:0]      pos_y,
  output logic [13:0]             magnitude,
  output logic                    moved
);

  // configuration
  logic [3:0]  track_shift;
  logic [11:0] max_step;
  logic [12:0] target_limit;
  logic [12:0] full_scale_mg;
  logic [9:0]  dial_radius;
  logic [9:0]  clip_radius;

  // tracker state
  logic signed [PosW-1:0] target_x, target_y, ball_x, ball_y;
  logic                   target_seen, sweep_active, moved_r;
  logic signed [PosW-1:0] target_x_next, target_y_next, ball_x_next, ball_y_next;
  logic                   target_seen_next, sweep_active_next, moved_next;

  // working registers
  logic [ProdW-1:0] prod;
  logic [AccW-1:0]  acc;
  logic [19:0]      rmsq;
  logic [MagW-1:0]  px_mag, py_mag;
  logic [RootW-1:0] cmag;
  logic [13:0]      mag_r;

  logic [MagW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_p;
  logic [PosW-1:0]  bx_abs, by_abs, tx_abs, ty_abs;
  logic [NumW-1:0]  div_q;
  logic [DenW-1:0]  div_den;
  logic [12:0]      fs_eff;
  logic [RootW-1:0] sq_root;
  logic [10:0]      px11, py11;

  function automatic logic signed [PosW-1:0] clamp_tgt(input logic signed [15:0] v,
                                                      input logic [12:0] lim);
    logic signed [16:0] vs, ls, nl;
    vs = {v[15], v};
    ls = {4'b0000, lim};
    nl = -ls;
    if (vs > ls) begin
      return ls[PosW-1:0];
    end else if (vs < nl) begin
      return nl[PosW-1:0];
    end
    return vs[PosW-1:0];
  endfunction

  // one smoothing step toward the target, at least one count, capped
  function automatic logic signed [PosW-1:0] step_axis(input logic signed [PosW-1:0] tgt,
                                                      input logic signed [PosW-1:0] pos,
                                                      input logic [3:0] sh,
                                                      input logic [11:0] cap);
    logic signed [PosW:0] d, s, c, nc, n;
    d  = {tgt[PosW-1], tgt} - {pos[PosW-1], pos};
    s  = d >>> sh;
    c  = {3'b000, cap};
    nc = -c;
    if (s == 0 && d != 0) begin
      s = 15'sd1;
    end
    if (s > c) begin
      s = c;
    end else if (s < nc) begin
      s = nc;
    end
    n = {pos[PosW-1], pos} + s;
    return n[PosW-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      track_shift   <= 4'd4;
      max_step      <= 12'd50;
      target_limit  <= 13'd4000;
      full_scale_mg <= 13'd1500;
      dial_radius   <= 10'd200;
      clip_radius   <= 10'd185;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRACK_SHIFT:  track_shift   <= cfg_data[3:0];
        REG_MAX_STEP:     max_step      <= cfg_data[11:0];
        REG_TARGET_LIMIT: target_limit  <= cfg_data[12:0];
        REG_FULL_SCALE:   full_scale_mg <= cfg_data[12:0];
        REG_DIAL_RADIUS:  dial_radius   <= cfg_data[9:0];
        REG_CLIP_RADIUS:  clip_radius   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // next tracker state for the accepted item
  always_comb begin
    target_x_next     = target_x;
    target_y_next     = target_y;
    ball_x_next       = ball_x;
    ball_y_next       = ball_y;
    target_seen_next  = target_seen;
    sweep_active_next = sweep_active;
    moved_next        = 1'b0;
    case (action)
      ACT_SET_TARGET: begin
        target_x_next = clamp_tgt(accel_x, target_limit);
        target_y_next = clamp_tgt(accel_y, target_limit);
        if (!target_seen) begin
          ball_x_next      = target_x_next;
          ball_y_next      = target_y_next;
          target_seen_next = 1'b1;
          moved_next       = 1'b1;
        end
      end
      ACT_TICK: begin
        if (!sweep_active) begin
          ball_x_next = step_axis(target_x, ball_x, track_shift, max_step);
          ball_y_next = step_axis(target_y, ball_y, track_shift, max_step);
          moved_next  = (ball_x_next != ball_x) || (ball_y_next != ball_y);
        end
      end
      ACT_SWEEP_GO: begin
        sweep_active_next = 1'b1;
        ball_x_next       = '0;
        ball_y_next       = '0;
        moved_next        = 1'b1;
      end
      ACT_SWEEP_POS: begin
        if (sweep_active) begin
          ball_x_next = {1'b0, sweep_offset};
          ball_y_next = '0;
          moved_next  = 1'b1;
        end
      end
      ACT_SWEEP_END: begin
        if (sweep_active) begin
          sweep_active_next = 1'b0;
          ball_x_next       = '0;
          ball_y_next       = '0;
          moved_next        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x     <= '0;
      target_y     <= '0;
      ball_x       <= '0;
      ball_y       <= '0;
      target_seen  <= 1'b0;
      sweep_active <= 1'b0;
      moved_r      <= 1'b0;
    end else if (cmd.update) begin
      target_x     <= target_x_next;
      target_y     <= target_y_next;
      ball_x       <= ball_x_next;
      ball_y       <= ball_y_next;
      target_seen  <= target_seen_next;
      sweep_active <= sweep_active_next;
      moved_r      <= moved_next;
    end
  end

  // magnitudes of the signed values
  assign bx_abs = ball_x[PosW-1]   ? PosW'(-ball_x)   : PosW'(ball_x);
  assign by_abs = ball_y[PosW-1]   ? PosW'(-ball_y)   : PosW'(ball_y);
  assign tx_abs = target_x[PosW-1] ? PosW'(-target_x) : PosW'(target_x);
  assign ty_abs = target_y[PosW-1] ? PosW'(-target_y) : PosW'(target_y);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_BALL_X: begin mul_a = MagW'(bx_abs);      mul_b = MagW'(dial_radius); end
      MUL_BALL_Y: begin mul_a = MagW'(by_abs);      mul_b = MagW'(dial_radius); end
      MUL_PX_SQ:  begin mul_a = px_mag;             mul_b = px_mag;             end
      MUL_PY_SQ:  begin mul_a = py_mag;             mul_b = py_mag;             end
      MUL_RM_SQ:  begin mul_a = MagW'(clip_radius); mul_b = MagW'(clip_radius); end
      MUL_CLIP_X: begin mul_a = px_mag;             mul_b = MagW'(clip_radius); end
      MUL_CLIP_Y: begin mul_a = py_mag;             mul_b = MagW'(clip_radius); end
      MUL_TX_SQ:  begin mul_a = MagW'(tx_abs);      mul_b = MagW'(tx_abs);      end
      MUL_TY_SQ:  begin mul_a = MagW'(ty_abs);      mul_b = MagW'(ty_abs);      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divisor: full scale for pixel mapping, radius for clipping
  assign fs_eff  = (full_scale_mg == '0) ? 13'd1 : full_scale_mg;
  assign div_den = (cmd.div_src == DSRC_CLIP) ? cmag : DenW'(fs_eff);

  gbt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (prod[NumW-1:0]),
    .den  (div_den),
    .done (stat.div_done),
    .quo  (div_q)
  );

  gbt_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .rad_in({1'b0, acc}),
    .done  (stat.sqrt_done),
    .root  (sq_root)
  );

  // ball outside the clip circle
  assign stat.clip = acc > AccW'(rmsq);

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    unique case (cmd.acc_op)
      ACC_LOAD: acc <= AccW'(prod);
      ACC_ADD:  acc <= acc + AccW'(prod);
      default: ;
    endcase
    if (cmd.rmsq_load) begin
      rmsq <= prod[19:0];
    end
    unique case (cmd.q_dst)
      QDST_PX: px_mag <= div_q[MagW-1:0];
      QDST_PY: py_mag <= div_q[MagW-1:0];
      default: ;
    endcase
    if (cmd.cmag_load) begin
      cmag <= sq_root;
    end
    if (cmd.mag_load) begin
      mag_r <= sq_root[13:0];
    end
  end

  // result register, y flipped to point down
  assign px11 = px_mag[10:0];
  assign py11 = py_mag[10:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x     <= ball_x[PosW-1] ? 11'(-px11) : px11;
      pos_y     <= ball_y[PosW-1] ? py11 : 11'(-py11);
      magnitude <= mag_r;
      moved     <= moved_r;
    end
  end

endmodule

`default_nettype wire

/* hdl/gbt_ctrl.sv */
// ----------------------------------------------------------------------------
// gbt_ctrl
// Sequencer of the g-force ball tracker: handshakes and datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_ctrl import gbt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire gbt_stat_t stat,
  output gbt_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_MBX, S_DVX, S_WDX, S_MBY, S_DVY, S_WDY,
    S_MPX, S_MPY, S_MRM, S_CMP, S_CHK,
    S_SQC, S_WSQC, S_MCX, S_DCX, S_WCX, S_MCY, S_DCY, S_WCY,
    S_MTX, S_MTY, S_MAC, S_SQM, S_WSQM, S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // step commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.update = in_valid;
        if (in_valid) state_next = S_MBX;
      end
      // pixel mapping, x then y
      S_MBX: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_BALL_X; state_next = S_DVX; end
      S_DVX: begin cmd.div_start = 1'b1; cmd.div_src = DSRC_PIXEL; state_next = S_WDX; end
      S_WDX: begin
        if (stat.div_done) begin cmd.q_dst = QDST_PX; state_next = S_MBY; end
      end
      S_MBY: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_BALL_Y; state_next = S_DVY; end
      S_DVY: begin cmd.div_start = 1'b1; cmd.div_src = DSRC_PIXEL; state_next = S_WDY; end
      S_WDY: begin
        if (stat.div_done) begin cmd.q_dst = QDST_PY; state_next = S_MPX; end
      end
      // squared radius against the clip radius
      S_MPX: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_PX_SQ; state_next = S_MPY; end
      S_MPY: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_PY_SQ; cmd.acc_op = ACC_LOAD;
        state_next = S_MRM;
      end
      S_MRM: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_RM_SQ; cmd.acc_op = ACC_ADD;
        state_next = S_CMP;
      end
      S_CMP: begin cmd.rmsq_load = 1'b1; state_next = S_CHK; end
      S_CHK: state_next = stat.clip ? S_SQC : S_MTX;
      // clip onto the circle
      S_SQC: begin cmd.sqrt_start = 1'b1; state_next = S_WSQC; end
      S_WSQC: begin
        if (stat.sqrt_done) begin cmd.cmag_load = 1'b1; state_next = S_MCX; end
      end
      S_MCX: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_CLIP_X; state_next = S_DCX; end
      S_DCX: begin cmd.div_start = 1'b1; cmd.div_src = DSRC_CLIP; state_next = S_WCX; end
      S_WCX: begin
        if (stat.div_done) begin cmd.q_dst = QDST_PX; state_next = S_MCY; end
      end
      S_MCY: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_CLIP_Y; state_next = S_DCY; end
      S_DCY: begin cmd.div_start = 1'b1; cmd.div_src = DSRC_CLIP; state_next = S_WCY; end
      S_WCY: begin
        if (stat.div_done) begin cmd.q_dst = QDST_PY; state_next = S_MTX; end
      end
      // target magnitude
      S_MTX: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_TX_SQ; state_next = S_MTY; end
      S_MTY: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_TY_SQ; cmd.acc_op = ACC_LOAD;
        state_next = S_MAC;
      end
      S_MAC: begin cmd.acc_op = ACC_ADD; state_next = S_SQM; end
      S_SQM: begin cmd.sqrt_start = 1'b1; state_next = S_WSQM; end
      S_WSQM: begin
        if (stat.sqrt_done) begin cmd.mag_load = 1'b1; state_next = S_DONE; end
      end
      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin cmd.out_load = 1'b1; state_next = S_IDLE; end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // divider results arrive only while waiting for them
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_WDX || state == S_WDY || state == S_WCX || state == S_WCY))
    else $error("divider done outside a divide wait");

  a_sqrt_wait: assert property (@(posedge clk) disable iff (rst)
    stat.sqrt_done |-> (state == S_WSQC || state == S_WSQM))
    else $error("square root done outside a root wait");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && out_valid) |-> out_ready)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

/* hdl/gforce_ball_tracker_top.sv */
// ----------------------------------------------------------------------------
// gforce_ball_tracker_top
// Two-axis g-force ball tracker with pixel mapping and target magnitude.
// ----------------------------------------------------------------------------
// Usage: each item on the input channel (in_valid/in_ready) carries an
// action and its operands; each yields exactly one result item on the output
// channel (out_valid/out_ready) with the ball's pixel offset, the target's
// magnitude and a moved flag. The user must write registers through cfg_we,
// cfg_index and cfg_data only while no item is in work; the block itself
// does not enforce this, and writes take effect at once. One item is
// processed at a time. The time from accept to result valid is spent
// mostly in the shared bit-serial divider (two divides, or four when the
// ball lies outside the clip circle) and the shared square root unit (once,
// or twice with clipping). in_ready is high only while the sequencer is
// idle, so a new item is taken only once the previous one has finished.
// The result sits in an output register, so the next item is accepted while
// a finished result waits; if the receiver still stalls when that next item
// completes, the sequencer holds until the register is free.
// Reset (rst, synchronous) clears the ball, target, sweep and first-target
// state and loads the register defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gforce_ball_tracker_top import gbt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         action,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic [12:0]        sweep_offset,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [10:0]      pos_x,
  output logic signed [10:0]      pos_y,
  output logic [13:0]             magnitude,
  output logic                    moved,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data
);

  gbt_cmd_t  cmd;
  gbt_stat_t stat;

  // sequencer
  gbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state, registers and arithmetic
  gbt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .action      (action),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .sweep_offset(sweep_offset),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .magnitude   (magnitude),
    .moved       (moved)
  );

endmodule

`default_nettype wire
